/* rtl/pgtb_pkg.sv */
package pgtb_pkg;

  localparam int COORD_W   = 16;
  localparam int RAD_W     = 15;
  localparam int MAG_W     = 17;
  localparam int PROD_W    = 34;
  localparam int DIST_W    = 35;
  localparam int RSQ_W     = 30;
  localparam int GOAL_W    = 48;
  localparam int STEP_W    = 4;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_WARN   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DANGER = 1'b1;

  localparam logic [1:0] LEVEL_CLEAR  = 2'd0;
  localparam logic [1:0] LEVEL_WARN   = 2'd1;
  localparam logic [1:0] LEVEL_DANGER = 2'd2;

  localparam logic [1:0] HOVER_NONE    = 2'd0;
  localparam logic [1:0] HOVER_RELEASE = 2'd1;
  localparam logic [1:0] HOVER_HOLD    = 2'd2;

  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd15;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    SRC_WARN,
    SRC_DANGER,
    SRC_LX,
    SRC_LY,
    SRC_LZ,
    SRC_GX,
    SRC_GY,
    SRC_GZ
  } src_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_WR2,
    DST_DR2,
    DST_D
  } dst_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FLAGS,
    ACT_DECIDE,
    ACT_SCAN,
    ACT_TRY,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_BRANCH,
    SEQ_SCAN,
    SEQ_EMIT
  } seq_t;

  typedef enum logic [1:0] {
    MODE_UNARMED = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_TRYING  = 2'd2
  } mode_t;

  typedef struct packed {
    src_t    src;
    logic    ld_diff;
    logic    ld_prod;
    acc_op_t acc;
    dst_t    dst;
    act_t    act;
    seq_t    seq;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic danger;
    logic warn;
    logic closing;
    logic far;
  } flags_t;

  typedef struct packed {
    logic armed;
    logic scan_busy;
    logic out_free;
  } guard_stat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] leader_x;
    logic signed [COORD_W-1:0] leader_y;
    logic signed [COORD_W-1:0] leader_z;
    logic signed [COORD_W-1:0] follower_x;
    logic signed [COORD_W-1:0] follower_y;
    logic signed [COORD_W-1:0] follower_z;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [COORD_W-1:0] goal_z;
  } sample_t;

  typedef struct packed {
    logic [1:0] level;
    logic [1:0] leader_hover;
    logic [1:0] follower_hover;
    logic       follower_reset;
    logic       list_full;
  } result_t;

  function automatic ctrl_t mk(src_t src, logic ld_diff, logic ld_prod, acc_op_t acc,
                               dst_t dst, act_t act, seq_t seq, step_t target);
    ctrl_t c;
    c.src     = src;
    c.ld_diff = ld_diff;
    c.ld_prod = ld_prod;
    c.acc     = acc;
    c.dst     = dst;
    c.act     = act;
    c.seq     = seq;
    c.target  = target;
    return c;
  endfunction

  // Squares are overlapped: operand select, multiply and accumulate each work
  // on a different square in the same step.
  function automatic ctrl_t program_word(step_t step);
    ctrl_t c;
    unique case (step)
      4'd0:    c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_NONE,   SEQ_WAIT_IN, STEP_WAIT);
      4'd1:    c = mk(SRC_WARN,   1'b1, 1'b0, ACC_HOLD, DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd2:    c = mk(SRC_DANGER, 1'b1, 1'b1, ACC_HOLD, DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd3:    c = mk(SRC_LX,     1'b1, 1'b1, ACC_HOLD, DST_WR2,  ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd4:    c = mk(SRC_LY,     1'b1, 1'b1, ACC_HOLD, DST_DR2,  ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd5:    c = mk(SRC_LZ,     1'b1, 1'b1, ACC_LOAD, DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd6:    c = mk(SRC_GX,     1'b1, 1'b1, ACC_ADD,  DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd7:    c = mk(SRC_GY,     1'b1, 1'b1, ACC_ADD,  DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd8:    c = mk(SRC_GZ,     1'b1, 1'b1, ACC_LOAD, DST_D,    ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd9:    c = mk(SRC_WARN,   1'b0, 1'b1, ACC_ADD,  DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd10:   c = mk(SRC_WARN,   1'b0, 1'b0, ACC_ADD,  DST_NONE, ACT_NONE,   SEQ_NEXT,    STEP_WAIT);
      4'd11:   c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_FLAGS,  SEQ_NEXT,    STEP_WAIT);
      4'd12:   c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_DECIDE, SEQ_BRANCH,  STEP_EMIT);
      4'd13:   c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_SCAN,   SEQ_SCAN,    STEP_WAIT);
      4'd14:   c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_TRY,    SEQ_NEXT,    STEP_WAIT);
      4'd15:   c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_EMIT,   SEQ_EMIT,    STEP_WAIT);
      default: c = mk(SRC_WARN,   1'b0, 1'b0, ACC_HOLD, DST_NONE, ACT_NONE,   SEQ_EMIT,    STEP_WAIT);
    endcase
    return c;
  endfunction

endpackage

/* rtl/pgtb_if.sv */
interface pgtb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] leader_x;
  logic signed [15:0] leader_y;
  logic signed [15:0] leader_z;
  logic signed [15:0] follower_x;
  logic signed [15:0] follower_y;
  logic signed [15:0] follower_z;
  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic signed [15:0] goal_z;

  modport source (
    output valid, leader_x, leader_y, leader_z, follower_x, follower_y, follower_z,
           goal_x, goal_y, goal_z,
    input  ready
  );

  modport sink (
    input  valid, leader_x, leader_y, leader_z, follower_x, follower_y, follower_z,
           goal_x, goal_y, goal_z,
    output ready
  );
endinterface

interface pgtb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] level;
  logic [1:0] leader_hover;
  logic [1:0] follower_hover;
  logic       follower_reset;
  logic       list_full;

  modport source (
    output valid, level, leader_hover, follower_hover, follower_reset, list_full,
    input  ready
  );

  modport sink (
    input  valid, level, leader_hover, follower_hover, follower_reset, list_full,
    output ready
  );
endinterface

/* rtl/pgtb_seq.sv */
module pgtb_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  pgtb_pkg::flags_t      flags,
  input  pgtb_pkg::guard_stat_t stat,
  output pgtb_pkg::ctrl_t       cw
);
  import pgtb_pkg::*;

  step_t step;
  step_t step_next;

  assign cw = program_word(step);

  always_comb begin
    step_next = step;
    unique case (cw.seq)
      SEQ_NEXT:    step_next = step + 4'd1;
      SEQ_WAIT_IN: if (accept) step_next = step + 4'd1;
      SEQ_BRANCH:  begin
        if (flags.warn && !flags.danger && stat.armed) step_next = step + 4'd1;
        else step_next = cw.target;
      end
      SEQ_SCAN:    if (!stat.scan_busy) step_next = step + 4'd1;
      SEQ_EMIT:    if (stat.out_free) step_next = cw.target;
      default:     step_next = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* rtl/pgtb_arith.sv */
module pgtb_arith (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  pgtb_pkg::sample_t                   smp,
  input  pgtb_pkg::ctrl_t                     cw,
  input  logic                                wr_en,
  input  logic [pgtb_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [pgtb_pkg::RAD_W-1:0]          wr_data,
  output pgtb_pkg::flags_t                    flags,
  output logic [pgtb_pkg::GOAL_W-1:0]         goal_pk
);
  import pgtb_pkg::*;

  sample_t             smp_q;
  logic [RAD_W-1:0]    warn_radius;
  logic [RAD_W-1:0]    danger_radius;
  logic [COORD_W-1:0]  opa;
  logic [COORD_W-1:0]  opb;
  logic signed [MAG_W-1:0] sdiff;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    diff_mag;
  logic [PROD_W-1:0]   sq;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   acc;
  logic [DIST_W-1:0]   sep_sq;
  logic [DIST_W-1:0]   prev_dist;
  logic [RSQ_W-1:0]    wr2;
  logic [RSQ_W-1:0]    dr2;

  assign goal_pk = {smp_q.goal_z, smp_q.goal_y, smp_q.goal_x};

  always_comb begin
    unique case (cw.src)
      SRC_LX:  begin opa = smp_q.leader_x; opb = smp_q.follower_x; end
      SRC_LY:  begin opa = smp_q.leader_y; opb = smp_q.follower_y; end
      SRC_LZ:  begin opa = smp_q.leader_z; opb = smp_q.follower_z; end
      SRC_GX:  begin opa = smp_q.goal_x;   opb = smp_q.leader_x;   end
      SRC_GY:  begin opa = smp_q.goal_y;   opb = smp_q.leader_y;   end
      SRC_GZ:  begin opa = smp_q.goal_z;   opb = smp_q.leader_z;   end
      default: begin opa = '0;             opb = '0;               end
    endcase
    sdiff = $signed({opa[COORD_W-1], opa}) - $signed({opb[COORD_W-1], opb});
    unique case (cw.src)
      SRC_WARN:   mag = MAG_W'(warn_radius);
      SRC_DANGER: mag = MAG_W'(danger_radius);
      default:    mag = sdiff[MAG_W-1] ? MAG_W'(-sdiff) : MAG_W'(sdiff);
    endcase
  end

  assign sq = PROD_W'(diff_mag) * PROD_W'(diff_mag);

  always_ff @(posedge clk) begin
    if (accept) smp_q <= smp;
    if (cw.ld_diff) diff_mag <= mag;
    if (cw.ld_prod) prod <= sq;
    case (cw.acc)
      ACC_LOAD: acc <= DIST_W'(prod);
      ACC_ADD:  acc <= acc + DIST_W'(prod);
      default:  acc <= acc;
    endcase
    case (cw.dst)
      DST_WR2: wr2    <= prod[RSQ_W-1:0];
      DST_DR2: dr2    <= prod[RSQ_W-1:0];
      DST_D:   sep_sq <= acc;
      default: sep_sq <= sep_sq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_radius   <= RAD_W'(1000);
      danger_radius <= RAD_W'(700);
      prev_dist     <= '0;
      flags         <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_WARN:   warn_radius   <= wr_data;
          REG_DANGER: danger_radius <= wr_data;
          default:    warn_radius   <= warn_radius;
        endcase
      end
      if (cw.act == ACT_FLAGS) begin
        flags     <= {(sep_sq <= DIST_W'(dr2)), (sep_sq <= DIST_W'(wr2)),
                      (sep_sq < prev_dist), (acc > DIST_W'(wr2))};
        prev_dist <= sep_sq;
      end
    end
  end

endmodule

/* rtl/pgtb_guard.sv */
module pgtb_guard #(
  parameter int BLACKLIST_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pgtb_pkg::ctrl_t             cw,
  input  pgtb_pkg::flags_t            flags,
  input  logic [pgtb_pkg::GOAL_W-1:0] goal_pk,
  input  logic                        out_ready,
  output pgtb_pkg::guard_stat_t       stat,
  output logic                        out_valid,
  output pgtb_pkg::result_t           out_data
);
  import pgtb_pkg::*;

  localparam int CW = $clog2(BLACKLIST_DEPTH + 1);
  localparam int AW = (BLACKLIST_DEPTH > 1) ? $clog2(BLACKLIST_DEPTH) : 1;

  logic [GOAL_W-1:0] mem [BLACKLIST_DEPTH];
  logic [GOAL_W-1:0] rd_data;
  logic [GOAL_W-1:0] trial_goal;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic              rd_valid;
  logic              bad;
  logic              has_room;
  logic              mem_we;
  logic              scan_rd;
  logic              emit;
  mode_t             mode;
  result_t           res;
  result_t           res_dec;

  assign has_room = count < CW'(BLACKLIST_DEPTH);
  assign mem_we   = (cw.act == ACT_DECIDE) && !flags.danger && flags.warn &&
                    (mode == MODE_TRYING) && flags.closing && has_room;
  assign scan_rd  = (cw.act == ACT_SCAN) && (idx < count);
  assign emit     = (cw.act == ACT_EMIT) && stat.out_free;

  assign stat.armed     = mode == MODE_ARMED;
  assign stat.scan_busy = (idx < count) || rd_valid;
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    res_dec = '0;
    if (flags.danger) begin
      res_dec.level          = LEVEL_DANGER;
      res_dec.follower_reset = 1'b1;
    end else if (flags.warn) begin
      res_dec.level = LEVEL_WARN;
      if (mode == MODE_ARMED) begin
        res_dec.leader_hover   = HOVER_HOLD;
        res_dec.follower_hover = HOVER_HOLD;
      end else if (mode == MODE_TRYING && flags.closing && !has_room) begin
        res_dec.list_full = 1'b1;
      end
    end else begin
      res_dec.level          = LEVEL_CLEAR;
      res_dec.leader_hover   = HOVER_RELEASE;
      res_dec.follower_hover = HOVER_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[count[AW-1:0]] <= trial_goal;
    if (scan_rd) rd_data <= mem[idx[AW-1:0]];
    if (emit) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_UNARMED;
      count      <= '0;
      idx        <= '0;
      rd_valid   <= 1'b0;
      bad        <= 1'b0;
      trial_goal <= '0;
      res        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (cw.act)
        ACT_DECIDE: begin
          idx      <= '0;
          rd_valid <= 1'b0;
          bad      <= 1'b0;
          res      <= res_dec;
          if (!flags.danger) begin
            if (flags.warn) begin
              if (mode == MODE_TRYING && flags.closing) begin
                if (has_room) count <= count + CW'(1);
                mode <= MODE_ARMED;
              end
            end else begin
              mode  <= MODE_ARMED;
              count <= '0;
            end
          end
        end
        ACT_SCAN: begin
          rd_valid <= scan_rd;
          if (scan_rd) idx <= idx + CW'(1);
          if (rd_valid && rd_data == goal_pk) bad <= 1'b1;
        end
        ACT_TRY: begin
          if (!bad && flags.far) begin
            trial_goal         <= goal_pk;
            res.follower_hover <= HOVER_RELEASE;
            mode               <= MODE_TRYING;
          end
        end
        default: mode <= mode;
      endcase
    end
  end

endmodule

/* rtl/proximity_guard_with_target_blacklist.sv */
// Each input beat runs through the microcode steps to one result beat; a warning in the
// armed mode adds a search over the blacklist entries, and a stall on the result side
// holds the emit step.
// One item at a time: a new sample is taken only after the result of the last one has
// been emitted, set by the microcode step counter and the single squaring multiplier.
// Reset (synchronous, active high) restores the radii to 1000 and 700 mm,
// leaves the guard unarmed with an empty blacklist and drops any held result.
module proximity_guard_with_target_blacklist #(
  parameter int BLACKLIST_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  pgtb_in_if.sink                             sample,
  pgtb_out_if.source                          result,
  input  logic                                wr_en,
  input  logic [pgtb_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [pgtb_pkg::RAD_W-1:0]          wr_data
);
  import pgtb_pkg::*;

  ctrl_t             cw;
  flags_t            flags;
  guard_stat_t       stat;
  sample_t           smp;
  result_t           out_data;
  logic              accept;
  logic [GOAL_W-1:0] goal_pk;

  assign sample.ready = cw.seq == SEQ_WAIT_IN;
  assign accept       = sample.valid && sample.ready;

  assign smp.leader_x   = sample.leader_x;
  assign smp.leader_y   = sample.leader_y;
  assign smp.leader_z   = sample.leader_z;
  assign smp.follower_x = sample.follower_x;
  assign smp.follower_y = sample.follower_y;
  assign smp.follower_z = sample.follower_z;
  assign smp.goal_x     = sample.goal_x;
  assign smp.goal_y     = sample.goal_y;
  assign smp.goal_z     = sample.goal_z;

  pgtb_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .flags  (flags),
    .stat   (stat),
    .cw     (cw)
  );

  pgtb_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .smp      (smp),
    .cw       (cw),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .flags    (flags),
    .goal_pk  (goal_pk)
  );

  pgtb_guard #(
    .BLACKLIST_DEPTH (BLACKLIST_DEPTH)
  ) u_guard (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .flags     (flags),
    .goal_pk   (goal_pk),
    .out_ready (result.ready),
    .stat      (stat),
    .out_valid (result.valid),
    .out_data  (out_data)
  );

  assign result.level          = out_data.level;
  assign result.leader_hover   = out_data.leader_hover;
  assign result.follower_hover = out_data.follower_hover;
  assign result.follower_reset = out_data.follower_reset;
  assign result.list_full      = out_data.list_full;

endmodule

/* rtl/pgtb_checker.sv */
module pgtb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] level,
  input logic [1:0] leader_hover,
  input logic [1:0] follower_hover,
  input logic       follower_reset,
  input logic       list_full
);
  import pgtb_pkg::*;

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({level, leader_hover, follower_hover, follower_reset, list_full}))
    else $error("result beat changed while stalled");

  a_danger_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && level == LEVEL_DANGER |-> follower_reset &&
      leader_hover == HOVER_NONE && follower_hover == HOVER_NONE && !list_full)
    else $error("danger beat without a lone follower reset");

  a_clear_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && level == LEVEL_CLEAR |-> !follower_reset && !list_full &&
      leader_hover == HOVER_RELEASE && follower_hover == HOVER_RELEASE)
    else $error("clear beat without a release of both craft");

  a_full_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_full |-> level == LEVEL_WARN && !follower_reset &&
      leader_hover == HOVER_NONE && follower_hover == HOVER_NONE)
    else $error("blacklist overflow outside a closing warning");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

endmodule

bind proximity_guard_with_target_blacklist pgtb_checker u_pgtb_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (sample.valid),
  .in_ready       (sample.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .level          (result.level),
  .leader_hover   (result.leader_hover),
  .follower_hover (result.follower_hover),
  .follower_reset (result.follower_reset),
  .list_full      (result.list_full)
);

/* tb/sv/proximity_guard_watch.sv */
module proximity_guard_watch #(
  parameter int BLACKLIST_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  pgtb_in_if                             sample,
  pgtb_out_if                            result,
  input  logic                           wr_en,
  input  logic [pgtb_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [pgtb_pkg::RAD_W-1:0]     wr_data,
  output int                             failures,
  output int                             pending,
  output int                             compared,
  output int                             blacklisted,
  output int                             dropped,
  output int                             dangers
);
  import pgtb_pkg::*;

  localparam logic [RAD_W-1:0] RESET_WARN   = 15'd1000;
  localparam logic [RAD_W-1:0] RESET_DANGER = 15'd700;

  typedef logic [2:0][COORD_W-1:0] point_t;

  logic [RAD_W-1:0]  warn_r;
  logic [RAD_W-1:0]  danger_r;
  logic [DIST_W-1:0] last_sep_sq;
  mode_t             mode;
  logic [GOAL_W-1:0] trial_goal;
  logic [GOAL_W-1:0] rejected [BLACKLIST_DEPTH];
  int                rejected_n;
  result_t           awaited [$];

  function automatic logic [DIST_W-1:0] span_sq(point_t p, point_t q);
    logic [DIST_W-1:0]         acc;
    logic signed [MAG_W-1:0]   diff;
    logic [MAG_W-1:0]          mag;
    int                        i;
    acc = '0;
    for (i = 0; i < 3; i++) begin
      diff = $signed(p[i]) - $signed(q[i]);
      mag = (diff < 0) ? -diff : diff;
      acc = acc + mag * mag;
    end
    return acc;
  endfunction

  function automatic result_t guard_response(sample_t s);
    result_t           r;
    point_t            lead;
    point_t            goal;
    logic [DIST_W-1:0] sep;
    logic [RSQ_W-1:0]  wr2;
    logic [RSQ_W-1:0]  dr2;
    logic              hit;
    int                i;
    r = '0;
    lead = {s.leader_z, s.leader_y, s.leader_x};
    goal = {s.goal_z, s.goal_y, s.goal_x};
    sep = span_sq(lead, {s.follower_z, s.follower_y, s.follower_x});
    wr2 = warn_r * warn_r;
    dr2 = danger_r * danger_r;
    if (sep <= dr2) begin
      r.level = LEVEL_DANGER;
      r.follower_reset = 1'b1;
      dangers++;
    end else if (sep <= wr2) begin
      r.level = LEVEL_WARN;
      if (mode == MODE_ARMED) begin
        r.leader_hover = HOVER_HOLD;
        r.follower_hover = HOVER_HOLD;
        hit = 1'b0;
        for (i = 0; i < rejected_n; i++) begin
          if (rejected[i] == goal) hit = 1'b1;
        end
        if (!hit && span_sq(goal, lead) > wr2) begin
          trial_goal = goal;
          r.follower_hover = HOVER_RELEASE;
          mode = MODE_TRYING;
        end
      end else if (mode == MODE_TRYING && sep < last_sep_sq) begin
        if (rejected_n < BLACKLIST_DEPTH) begin
          rejected[rejected_n] = trial_goal;
          rejected_n++;
          blacklisted++;
        end else begin
          r.list_full = 1'b1;
          dropped++;
        end
        mode = MODE_ARMED;
      end
    end else begin
      r.leader_hover = HOVER_RELEASE;
      r.follower_hover = HOVER_RELEASE;
      mode = MODE_ARMED;
      rejected_n = 0;
    end
    last_sep_sq = sep;
    return r;
  endfunction

  task automatic compare_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    sample_t tick;
    if (rst) begin
      warn_r = RESET_WARN;
      danger_r = RESET_DANGER;
      last_sep_sq = '0;
      mode = MODE_UNARMED;
      trial_goal = '0;
      rejected_n = 0;
      awaited.delete();
      failures = 0;
      compared = 0;
      blacklisted = 0;
      dropped = 0;
      dangers = 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_WARN) warn_r = wr_data;
        else if (wr_index == REG_DANGER) danger_r = wr_data;
      end
      if (result.valid && result.ready) begin
        got = {result.level, result.leader_hover, result.follower_hover,
               result.follower_reset, result.list_full};
        if (awaited.size() == 0) begin
          $error("result beat with no tick waiting for it");
          failures++;
        end else begin
          want = awaited.pop_front();
          compare_field("level", want.level, got.level);
          compare_field("leader_hover", want.leader_hover, got.leader_hover);
          compare_field("follower_hover", want.follower_hover, got.follower_hover);
          compare_field("follower_reset", 2'(want.follower_reset),
                        2'(got.follower_reset));
          compare_field("list_full", 2'(want.list_full), 2'(got.list_full));
          compared++;
        end
      end
      if (sample.valid && sample.ready) begin
        tick = {sample.leader_x, sample.leader_y, sample.leader_z,
                sample.follower_x, sample.follower_y, sample.follower_z,
                sample.goal_x, sample.goal_y, sample.goal_z};
        awaited = {awaited, guard_response(tick)};
      end
    end
    pending <= awaited.size();
  end

endmodule

/* tb/sv/tb_proximity_guard_with_target_blacklist.sv */
module tb_proximity_guard_with_target_blacklist;
  import pgtb_pkg::*;

  localparam int DEPTH      = 16;
  localparam int POOL       = 24;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 40;

  typedef logic [2:0][COORD_W-1:0] pt_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [RAD_W-1:0]     wr_data;

  int failures;
  int pending;
  int compared;
  int blacklisted;
  int dropped;
  int dangers;

  int  ticks;
  int  settings_run;
  int  idle_cycles = 0;
  int  warn;
  int  danger;
  int  prev_sep;
  int  wobble;
  int  n_goals;
  bit  steady;
  pt_t center;
  pt_t goals [POOL];
  pt_t far_a;
  pt_t far_b;
  pt_t near_pt;
  pt_t edge_pt;

  pgtb_in_if  sample_ch ();
  pgtb_out_if result_ch ();

  proximity_guard_with_target_blacklist #(
    .BLACKLIST_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  proximity_guard_watch #(
    .BLACKLIST_DEPTH(DEPTH)
  ) watch (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .failures    (failures),
    .pending     (pending),
    .compared    (compared),
    .blacklisted (blacklisted),
    .dropped     (dropped),
    .dangers     (dangers)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 50);
  endfunction

  function automatic logic [COORD_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Moves a point along one random axis. Where neither direction stays in
  // range, the coordinate goes to the farther end of the range.
  function automatic pt_t shifted(pt_t p, int sep);
    int     ax;
    longint c;
    longint up;
    longint dn;
    ax = $urandom_range(0, 2);
    c = longint'($signed(p[ax]));
    up = c + sep;
    dn = c - sep;
    if (up <= 32767 && (dn < -32768 || $urandom_range(0, 1) == 1)) p[ax] = up[15:0];
    else if (dn >= -32768) p[ax] = dn[15:0];
    else p[ax] = (c < 0) ? 16'h7fff : 16'h8000;
    return p;
  endfunction

  function automatic sample_t make_tick(int sep, pt_t goal);
    sample_t s;
    pt_t     lead;
    int      i;
    for (i = 0; i < 3; i++) begin
      lead[i] = clamp16(longint'($signed(center[i])) +
                        int'($urandom_range(0, 2 * wobble)) - wobble);
    end
    {s.leader_z, s.leader_y, s.leader_x} = lead;
    {s.follower_z, s.follower_y, s.follower_x} = shifted(lead, sep);
    {s.goal_z, s.goal_y, s.goal_x} = goal;
    return s;
  endfunction

  function automatic int band_sep(bit closing);
    int lo;
    int hi;
    int r;
    lo = danger + 1;
    hi = warn;
    if (closing && prev_sep - 1 >= lo && prev_sep - 1 < hi) hi = prev_sep - 1;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_tick(sample_t s);
    int gap;
    sample_ch.valid <= 1'b1;
    {sample_ch.leader_x, sample_ch.leader_y, sample_ch.leader_z,
     sample_ch.follower_x, sample_ch.follower_y, sample_ch.follower_z,
     sample_ch.goal_x, sample_ch.goal_y, sample_ch.goal_z} <= s;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    ticks++;
    gap = idle_len();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_radii(int w, int d);
    warn = w;
    danger = d;
    wr_en <= 1'b1;
    wr_index <= REG_WARN;
    wr_data <= RAD_W'(w);
    @(posedge clk);
    wr_index <= REG_DANGER;
    wr_data <= RAD_W'(d);
    @(posedge clk);
    wr_en <= 1'b0;
    settings_run++;
  endtask

  task automatic run_setting(int w, int d, int n);
    int                    done;
    int                    k;
    int                    i;
    int                    r;
    int                    q;
    int                    sep;
    int                    s1;
    bit                    fill;
    sample_t               s;
    pt_t                   g;
    logic [8:0][COORD_W-1:0] raw;
    drain();
    set_radii(w, d);
    wobble = 20;
    done = 0;
    while (done < n) begin
      steady = ($urandom_range(0, 3) == 0);
      fill = (d + 2 <= w) && (w <= 20000) && ($urandom_range(0, 2) == 0);
      for (i = 0; i < 3; i++) center[i] = 16'(int'($urandom_range(0, 60000)) - 30000);
      n_goals = fill ? DEPTH + 4 : $urandom_range(2, 20);
      for (i = 0; i < n_goals; i++) goals[i] = shifted(center, w + int'($urandom_range(100, 4000)));
      prev_sep = w + 1;
      send_tick(make_tick(w + 1 + int'($urandom_range(0, 2000)), goals[0]));
      done++;
      if (fill) begin
        // Each pair arms a trial on a fresh goal and then closes in on it,
        // so the list overflows before the next clear tick.
        for (i = 0; i < n_goals; i++) begin
          s1 = $urandom_range(d + 2, w);
          send_tick(make_tick(s1, goals[i]));
          send_tick(make_tick($urandom_range(d + 1, s1 - 1), goals[i]));
        end
        done += 2 * n_goals;
      end
      k = $urandom_range(4, 40);
      if (k > n - done) k = (n > done) ? n - done : 0;
      for (i = 0; i < k; i++) begin
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 99);
        if (q < 70) g = goals[$urandom_range(0, n_goals - 1)];
        else if (q < 88) g = shifted(center, $urandom_range(0, w));
        else g = shifted(center, w + int'($urandom_range(0, 1)));
        if (r < 4) begin
          for (q = 0; q < 9; q++) raw[q] = 16'($urandom());
          s = sample_t'(raw);
        end else begin
          if (r < 11) sep = w + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3000));
          else if (r < 17 || d >= w) sep = ($urandom_range(0, 3) == 0) ? d : $urandom_range(0, d);
          else sep = band_sep($urandom_range(0, 99) < 60);
          prev_sep = sep;
          s = make_tick(sep, g);
        end
        send_tick(s);
      end
      done += k;
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    int stall;
    forever begin
      result_ch.ready <= 1'b1;
      if (steady) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = idle_len();
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a beat", idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_WARN;
    wr_data <= '0;
    sample_ch.valid <= 1'b0;
    {sample_ch.leader_x, sample_ch.leader_y, sample_ch.leader_z,
     sample_ch.follower_x, sample_ch.follower_y, sample_ch.follower_z,
     sample_ch.goal_x, sample_ch.goal_y, sample_ch.goal_z} <= '0;
    steady = 1'b0;
    wobble = 0;
    warn = 1000;
    danger = 700;
    prev_sep = 0;
    center = '0;
    n_goals = 0;
    ticks = 0;
    settings_run = 0;
    far_a = {16'sd0, 16'sd0, 16'sd3000};
    far_b = {16'sd0, -16'sd4000, 16'sd0};
    near_pt = {16'sd0, 16'sd0, 16'sd500};
    edge_pt = {16'sd0, 16'sd1000, 16'sd0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Warning and danger before any clear tick, then a clear tick from opposite corners.
    send_tick(make_tick(800, far_a));
    send_tick(make_tick(0, far_a));
    send_tick({{3{16'h8000}}, {3{16'h7fff}}, 16'h7fff, 16'h8000, 16'h7fff});
    // Armed: goal too near, goal exactly on the warning radius, then a trial.
    send_tick(make_tick(1000, near_pt));
    send_tick(make_tick(900, edge_pt));
    send_tick(make_tick(950, far_a));
    send_tick(make_tick(960, far_a));
    send_tick(make_tick(920, far_a));
    send_tick(make_tick(910, far_a));
    send_tick(make_tick(905, far_b));
    send_tick(make_tick(700, far_b));
    send_tick(make_tick(990, far_b));
    send_tick(make_tick(980, far_b));
    // A clear tick just past the radius empties the list again.
    send_tick(make_tick(1001, far_a));
    send_tick(make_tick(999, far_a));
    send_tick(make_tick(701, far_a));
    send_tick(make_tick(999, far_a));

    run_setting(1000, 700, 130);
    run_setting(32767, 32767, 30);
    run_setting(0, 0, 30);
    run_setting(32767, 0, 40);
    run_setting(0, 32767, 30);
    run_setting(3000, 2999, 50);
    run_setting(6000, 1500, 150);
    warn = $urandom_range(2, 20000);
    run_setting(warn, $urandom_range(0, warn - 2), 130);
    warn = $urandom_range(2, 20000);
    run_setting(warn, $urandom_range(0, warn - 2), 100);

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("summary: %0d ticks under %0d radius settings, %0d results compared",
             ticks, settings_run + 1, compared);
    $display("summary: %0d danger ticks, %0d goals blacklisted, %0d dropped on a full list",
             dangers, blacklisted, dropped);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
